// ===== design/kruf_pkg.sv =====
// ----------------------------------------------------------------------------
// kruf_pkg
// Shared types and constants of the union-find edge filter: item structs,
// table entry layout, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package kruf_pkg;

    localparam int NODE_W   = 6;
    localparam int MAX_NODES = 1 << NODE_W;
    localparam int RANK_W   = 3;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W    = 22;
    localparam int CNT_W    = 7;
    localparam int CFG_W    = 7;
    localparam int ENTRY_W  = NODE_W + RANK_W;

    localparam logic [CFG_W-1:0]  NODE_COUNT_RST = CFG_W'(MAX_NODES);
    localparam logic [RANK_W-1:0] RANK_MAX       = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX        = '1;

    typedef struct packed {
        logic                action;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_in_item;

    typedef struct packed {
        logic             accepted;
        logic             bad_node;
        logic [SUM_W-1:0] total_weight;
        logic [CNT_W-1:0] edges_taken;
    } t_out_item;

    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [RANK_W-1:0] rank;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_A,
        S_COMP_A,
        S_FIND_B,
        S_COMP_B,
        S_LINK,
        S_RAISE,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_IN_A,
        RD_A,
        RD_B,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_COMP_A,
        WR_COMP_B,
        WR_LINK_RB,
        WR_LINK_RA,
        WR_RAISE
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    clear;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        logic    cap_ra;
        logic    cap_rb;
        logic    acc_add;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic in_restart;
        logic in_bad;
        logic at_root;
        logic cur_is_a;
        logic cur_is_b;
        logic end_a;
        logic end_b;
        logic same_root;
        logic a_wins;
        logic raise;
        logic out_free;
    } t_sts;

endpackage

// ===== design/kruf_ram.sv =====
// ----------------------------------------------------------------------------
// kruf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kruf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/kruf_dp.sv =====
// ----------------------------------------------------------------------------
// kruf_dp
// Datapath: parent/rank table with per-entry valid bits, walk registers,
// running totals, node count register and the output item register.
// ----------------------------------------------------------------------------
module kruf_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kruf_pkg::t_cmd                 i_cmd,
    output kruf_pkg::t_sts                 o_sts,
    input  kruf_pkg::t_in_item             i_in_item,
    input  logic                           i_cfg_we,
    input  logic [kruf_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output kruf_pkg::t_out_item            o_out_item
);
    import kruf_pkg::*;

    logic [CFG_W-1:0]    r_node_count;
    logic [NODE_W-1:0]   r_a, r_b, r_cur, r_ra, r_rb;
    logic [WEIGHT_W-1:0] r_w;
    logic [RANK_W-1:0]   r_rank_a, r_rank_b;
    logic                r_acc, r_bad;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [MAX_NODES-1:0] r_vld;
    logic [NODE_W-1:0]   r_rd_addr;
    logic                r_rd_vld;
    logic                r_rd_byp;
    t_entry              r_byp_data;
    logic                r_out_valid;
    t_out_item           r_out_item;

    t_entry              ram_q;
    t_entry              q;
    logic                rd_en;
    logic [NODE_W-1:0]   rd_addr;
    logic                wr_en;
    logic [NODE_W-1:0]   wr_addr;
    t_entry              wr_data;
    logic [SUM_W:0]      sum_ext;
    logic [SUM_W-1:0]    n_sum;
    logic [CNT_W-1:0]    n_cnt;
    logic                in_bad;

    kruf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    // Never-written entry reads as its own root with rank zero.
    always_comb begin
        if (r_rd_byp) begin
            q = r_byp_data;
        end else if (r_rd_vld) begin
            q = ram_q;
        end else begin
            q.parent = r_rd_addr;
            q.rank   = '0;
        end
    end

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_cur;
        case (i_cmd.rd_sel)
            RD_IN_A: rd_addr = i_in_item.node_a;
            RD_A:    rd_addr = r_a;
            RD_B:    rd_addr = r_b;
            RD_NEXT: rd_addr = q.parent;
            default: rd_en   = 1'b0;
        endcase
    end

    always_comb begin
        wr_en          = 1'b1;
        wr_addr        = r_cur;
        wr_data.parent = r_ra;
        wr_data.rank   = q.rank;
        case (i_cmd.wr_sel)
            WR_COMP_A: begin
                wr_data.parent = r_ra;
            end
            WR_COMP_B: begin
                wr_data.parent = r_rb;
            end
            WR_LINK_RB: begin
                wr_addr        = r_rb;
                wr_data.parent = r_ra;
                wr_data.rank   = r_rank_b;
            end
            WR_LINK_RA: begin
                wr_addr        = r_ra;
                wr_data.parent = r_rb;
                wr_data.rank   = r_rank_a;
            end
            WR_RAISE: begin
                wr_addr        = r_rb;
                wr_data.parent = r_rb;
                wr_data.rank   = r_rank_b + RANK_W'(1);
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Saturating totals.
    always_comb begin
        sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(r_w);
        n_sum   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        n_cnt   = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);
    end

    assign in_bad = (CFG_W'(i_in_item.node_a) >= r_node_count)
                 || (CFG_W'(i_in_item.node_b) >= r_node_count);

    always_comb begin
        o_sts.in_restart = i_in_item.action;
        o_sts.in_bad     = in_bad;
        o_sts.at_root    = (q.parent == r_cur);
        o_sts.cur_is_a   = (r_cur == r_a);
        o_sts.cur_is_b   = (r_cur == r_b);
        o_sts.end_a      = (q.parent == r_ra);
        o_sts.end_b      = (q.parent == r_rb);
        o_sts.same_root  = (r_ra == r_rb);
        o_sts.a_wins     = (r_rank_a > r_rank_b);
        o_sts.raise      = (r_rank_a == r_rank_b) && (r_rank_b != RANK_MAX);
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_vld        <= '0;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_vld <= '0;
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                if (wr_en) begin
                    r_vld[wr_addr] <= 1'b1;
                end
                if (i_cmd.acc_add) begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= i_in_item.node_a;
            r_b   <= i_in_item.node_b;
            r_w   <= i_in_item.edge_weight;
            r_acc <= 1'b0;
            r_bad <= !i_in_item.action && in_bad;
        end
        if (i_cmd.acc_add) begin
            r_acc <= 1'b1;
        end
        if (rd_en) begin
            r_cur      <= rd_addr;
            r_rd_addr  <= rd_addr;
            r_rd_vld   <= r_vld[rd_addr];
            r_rd_byp   <= wr_en && (wr_addr == rd_addr);
            r_byp_data <= wr_data;
        end
        if (i_cmd.cap_ra) begin
            r_ra     <= r_cur;
            r_rank_a <= q.rank;
        end
        if (i_cmd.cap_rb) begin
            r_rb     <= r_cur;
            r_rank_b <= q.rank;
        end
        if (i_cmd.out_load) begin
            r_out_item.accepted     <= r_acc;
            r_out_item.bad_node     <= r_bad;
            r_out_item.total_weight <= r_sum;
            r_out_item.edges_taken  <= r_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== design/kruf_ctrl.sv =====
// ----------------------------------------------------------------------------
// kruf_ctrl
// Controller: sequences the two root walks, the path rewrites, the link and
// the result hand-off.
// ----------------------------------------------------------------------------
module kruf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_idle,
    input  kruf_pkg::t_sts i_sts,
    output kruf_pkg::t_cmd o_cmd
);
    import kruf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_sts.in_restart || i_sts.in_bad) ? S_DONE : S_FIND_A;
                end
            end
            S_FIND_A: begin
                if (i_sts.at_root) begin
                    n_state = i_sts.cur_is_a ? S_FIND_B : S_COMP_A;
                end
            end
            S_COMP_A: begin
                if (i_sts.end_a) begin
                    n_state = S_FIND_B;
                end
            end
            S_FIND_B: begin
                if (i_sts.at_root) begin
                    n_state = i_sts.cur_is_b ? S_LINK : S_COMP_B;
                end
            end
            S_COMP_B: begin
                if (i_sts.end_b) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                if (!i_sts.same_root && !i_sts.a_wins && i_sts.raise) begin
                    n_state = S_RAISE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RAISE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load     = 1'b0;
        o_cmd.clear    = 1'b0;
        o_cmd.rd_sel   = RD_NONE;
        o_cmd.wr_sel   = WR_NONE;
        o_cmd.cap_ra   = 1'b0;
        o_cmd.cap_rb   = 1'b0;
        o_cmd.acc_add  = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_restart) begin
                        o_cmd.clear = 1'b1;
                    end else if (!i_sts.in_bad) begin
                        o_cmd.rd_sel = RD_IN_A;
                    end
                end
            end
            S_FIND_A: begin
                if (i_sts.at_root) begin
                    o_cmd.cap_ra = 1'b1;
                    o_cmd.rd_sel = i_sts.cur_is_a ? RD_B : RD_A;
                end else begin
                    o_cmd.rd_sel = RD_NEXT;
                end
            end
            S_COMP_A: begin
                o_cmd.wr_sel = WR_COMP_A;
                o_cmd.rd_sel = i_sts.end_a ? RD_B : RD_NEXT;
            end
            S_FIND_B: begin
                if (i_sts.at_root) begin
                    o_cmd.cap_rb = 1'b1;
                    if (!i_sts.cur_is_b) begin
                        o_cmd.rd_sel = RD_B;
                    end
                end else begin
                    o_cmd.rd_sel = RD_NEXT;
                end
            end
            S_COMP_B: begin
                o_cmd.wr_sel = WR_COMP_B;
                if (!i_sts.end_b) begin
                    o_cmd.rd_sel = RD_NEXT;
                end
            end
            S_LINK: begin
                if (!i_sts.same_root) begin
                    o_cmd.acc_add = 1'b1;
                    o_cmd.wr_sel  = i_sts.a_wins ? WR_LINK_RB : WR_LINK_RA;
                end
            end
            S_RAISE: begin
                o_cmd.wr_sel = WR_RAISE;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_idle     = (r_state == S_IDLE);

endmodule

// ===== design/kruskal_union_find_edge_filter_core.sv =====
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter_core
// Minimum spanning tree edge filter over a union-find table. Edges arrive in
// ascending weight order; each one gets an item back saying whether it joined
// two sets, together with the running tree weight and edge count. An item with
// action set restarts: every node returns to its own set and the totals clear
// (the table is cleared at once through per-entry valid bits, no sweep). An
// edge with an endpoint not below node_count is flagged bad_node and changes
// nothing. One item is processed at a time. An edge walks each endpoint up to
// its root and rewrites the path behind it, then links the two roots; when
// two equal-rank roots are joined, the surviving root's rank is raised in a
// further step. Union by rank keeps the hop count from each endpoint to its
// root at 6 or less for 64 nodes. The parent/rank table answers one read per
// cycle: every hop of the root search and of the path rewrite is one table
// read. A new item is taken while the previous result still waits in the
// output register. node_count may be written only while the block idles.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_filter_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  kruf_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output kruf_pkg::t_out_item        o_out_item,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [kruf_pkg::CFG_W-1:0] i_cfg_data
);
    import kruf_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic idle;
    logic cfg_we;

    // Take node_count writes only between items.
    assign o_cfg_ready = idle;
    assign cfg_we      = i_cfg_valid && idle;

    kruf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_idle     (idle),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kruf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
